FILE: hdl/pwcp_pkg.sv
// Shared types and constants for the WAVE chunk parser.
package pwcp_pkg;

  typedef enum logic [1:0] {
    PH_RIFF = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_FMT   = 2'd1,
    KIND_DATA  = 2'd2
  } kind_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_HEADER    = 3'd1;
  localparam logic [2:0] ST_TRUNC_HDR = 3'd2;
  localparam logic [2:0] ST_TRUNC_DAT = 3'd3;
  localparam logic [2:0] ST_BAD_FMT   = 3'd4;
  localparam logic [2:0] ST_DUP_DATA  = 3'd5;
  localparam logic [2:0] ST_MISSING   = 3'd6;
  localparam logic [2:0] ST_BAD_FORM  = 3'd7;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] INT_MAX  = 32'h7FFF_FFFF;

  // Word handed from the front to the back through the queue.
  typedef struct packed {
    logic        sample_valid;
    logic [7:0]  sample_byte;
    logic        done;
    logic        hdr_err;
    logic [2:0]  pre_status;   // chunk or truncation status, before format checks
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [31:0] byte_rate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] plen;
  } job_t;

endpackage

FILE: hdl/pwcp_front.sv
// Front end: byte-wise RIFF/chunk walk producing one job word per byte.
module pwcp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last,
  output logic            in_stall,
  output logic            job_valid,
  output pwcp_pkg::job_t  job,
  input  logic            job_stall
);
  import pwcp_pkg::*;

  logic [31:0] cnt_r, cnt_nxt, rlen_r, rlen_nxt, pos_r, pos_nxt, clen_r, clen_nxt;
  logic [31:0] tag_r, tag_nxt, plen_r, plen_nxt;
  logic        tags_ok_r, tags_ok_nxt, fseen_r, fseen_nxt, pseen_r, pseen_nxt;
  phase_t      ph_r, ph_nxt;
  kind_t       kind_r, kind_nxt;
  logic [2:0]  cerr_r, cerr_nxt;
  logic [7:0]  fw_r [16];
  logic        fw_we;
  logic        take;
  logic [32:0] body_tot, limit, need;
  logic [31:0] pos_inc, size;
  logic [2:0]  p3;
  logic        sv;
  job_t        j;

  assign in_stall = job_stall;
  assign take     = in_valid && !job_stall;
  assign body_tot = {1'b0, clen_r} + {32'd0, clen_r[0]};
  assign p3       = pos_r[2:0];
  assign pos_inc  = pos_r + 32'd1;

  always_comb begin
    logic [31:0] ntag, nlen;
    logic [33:0] tot_n;
    cnt_nxt = (cnt_r == 32'hFFFF_FFFF) ? cnt_r : cnt_r + 32'd1;
    rlen_nxt = rlen_r; pos_nxt = pos_r; clen_nxt = clen_r; tag_nxt = tag_r;
    plen_nxt = plen_r; tags_ok_nxt = tags_ok_r; fseen_nxt = fseen_r;
    pseen_nxt = pseen_r; ph_nxt = ph_r; kind_nxt = kind_r; cerr_nxt = cerr_r;
    fw_we = 1'b0; sv = 1'b0;
    ntag = tag_r; nlen = clen_r; tot_n = '0; limit = '0; need = '0;
    unique case (ph_r)
      PH_RIFF: begin
        if (cnt_r < 32'd4) begin
          if (in_data_byte != TAG_RIFF[8*(3-cnt_r[1:0]) +: 8]) tags_ok_nxt = 1'b0;
        end else if (cnt_r < 32'd8) begin
          rlen_nxt[8*cnt_r[1:0] +: 8] = in_data_byte;
        end else if (cnt_r < 32'd12) begin
          if (in_data_byte != TAG_WAVE[8*(3-cnt_r[1:0]) +: 8]) tags_ok_nxt = 1'b0;
        end
        if (cnt_nxt >= 32'd12) begin
          ph_nxt = PH_HDR; pos_nxt = '0;
        end
      end
      PH_HDR: begin
        if (!p3[2]) begin
          ntag = {tag_r[23:0], in_data_byte};
          if (p3 == 3'd0) nlen = '0;
        end else begin
          nlen[8*p3[1:0] +: 8] = in_data_byte;
        end
        tag_nxt = ntag; clen_nxt = nlen;
        pos_nxt = {29'd0, p3} + 32'd1;
        if (p3 == 3'd7) begin
          tot_n = {2'b0, nlen} + {33'd0, nlen[0]};
          need  = tot_n[32:0] + {1'b0, cnt_nxt};
          limit = {1'b0, rlen_r} + 33'd8;
          if (need > limit) begin
            cerr_nxt = ST_TRUNC_DAT; ph_nxt = PH_STOP;
          end else begin
            kind_nxt = KIND_OTHER;
            if (ntag == TAG_FMT && (fseen_r || nlen < 32'd16)) begin
              cerr_nxt = ST_BAD_FMT; ph_nxt = PH_STOP;
            end else if (ntag == TAG_DATA && pseen_r) begin
              cerr_nxt = ST_DUP_DATA; ph_nxt = PH_STOP;
            end else begin
              if (ntag == TAG_FMT) begin
                fseen_nxt = 1'b1; kind_nxt = KIND_FMT;
              end else if (ntag == TAG_DATA) begin
                pseen_nxt = 1'b1; plen_nxt = nlen; kind_nxt = KIND_DATA;
              end
              pos_nxt = '0;
              ph_nxt = (tot_n == '0) ? PH_HDR : PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        fw_we = (kind_r == KIND_FMT) && (pos_r < 32'd16);
        sv    = (kind_r == KIND_DATA) && (pos_r < clen_r);
        pos_nxt = pos_inc;
        if ({1'b0, pos_inc} >= body_tot) begin
          ph_nxt = PH_HDR; pos_nxt = '0;
        end
      end
      PH_STOP: ;
      default: ;
    endcase
  end

  assign size = cnt_nxt;

  always_comb begin
    j = '0;
    j.sample_valid = sv;
    j.sample_byte  = sv ? in_data_byte : 8'd0;
    j.done         = in_last;
    j.hdr_err = (size < 32'd12) || (size > INT_MAX) || !tags_ok_nxt ||
                (rlen_nxt != size - 32'd8);
    if (cerr_nxt != ST_OK) j.pre_status = cerr_nxt;
    else if (ph_nxt == PH_HDR && pos_nxt != '0) j.pre_status = ST_TRUNC_HDR;
    else if (ph_nxt == PH_BODY) j.pre_status = ST_TRUNC_DAT;
    else if (!fseen_nxt || !pseen_nxt || plen_nxt == '0) j.pre_status = ST_MISSING;
    else j.pre_status = ST_OK;
    // Format bytes, with the byte written this cycle forwarded.
    begin
      logic [7:0] f [16];
      for (int i = 0; i < 16; i++)
        f[i] = (fw_we && pos_r[3:0] == 4'(i)) ? in_data_byte : fw_r[i];
      j.fmt_code  = {f[1], f[0]};
      j.chans     = {f[3], f[2]};
      j.rate      = {f[7], f[6], f[5], f[4]};
      j.byte_rate = {f[11], f[10], f[9], f[8]};
      j.align     = {f[13], f[12]};
      j.bits      = {f[15], f[14]};
    end
    j.plen = plen_nxt;
  end

  assign job_valid = in_valid;
  assign job       = j;

  always_ff @(posedge clk) begin
    if (!rst_n || (take && in_last)) begin
      cnt_r <= '0; rlen_r <= '0; pos_r <= '0; clen_r <= '0; tag_r <= '0;
      plen_r <= '0; tags_ok_r <= 1'b1; fseen_r <= 1'b0; pseen_r <= 1'b0;
      ph_r <= PH_RIFF; kind_r <= KIND_OTHER; cerr_r <= ST_OK;
      for (int i = 0; i < 16; i++) fw_r[i] <= 8'd0;
    end else if (take) begin
      cnt_r <= cnt_nxt; rlen_r <= rlen_nxt; pos_r <= pos_nxt; clen_r <= clen_nxt;
      tag_r <= tag_nxt; plen_r <= plen_nxt; tags_ok_r <= tags_ok_nxt;
      fseen_r <= fseen_nxt; pseen_r <= pseen_nxt; ph_r <= ph_nxt;
      kind_r <= kind_nxt; cerr_r <= cerr_nxt;
      if (fw_we) fw_r[pos_r[3:0]] <= in_data_byte;
    end
  end
endmodule

FILE: hdl/pwcp_queue.sv
// Two-entry queue between the front and the back.
module pwcp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  input  pwcp_pkg::job_t  wr_job,
  output logic            wr_stall,
  output logic            rd_valid,
  output pwcp_pkg::job_t  rd_job,
  input  logic            rd_stall
);
  import pwcp_pkg::*;

  job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = mem_r[rp_r];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_job;
  end
endmodule

FILE: hdl/pwcp_back.sv
// Back end: format checks and the frame count, registered, one job per cycle while the output is not stalled.
module pwcp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  pwcp_pkg::job_t  job,
  output logic            job_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_sample_valid,
  output logic [7:0]      out_sample_byte,
  output logic            out_done_res,
  output logic [2:0]      out_status,
  output logic [1:0]      out_channel_count,
  output logic [31:0]     out_sample_rate,
  output logic [4:0]      out_bits_per_sample,
  output logic [31:0]     out_frame_count,
  output logic [2:0]      out_frame_bytes,
  output logic [31:0]     out_payload_length
);
  import pwcp_pkg::*;

  logic        vld_r;
  logic        sv_r, done_r;
  logic [7:0]  sb_r;
  logic [2:0]  st_r, blk_r;
  logic [1:0]  ch_r;
  logic [31:0] rate_r, plen_r;
  logic [4:0]  bits_r;
  logic        adv;
  logic [2:0]  st, blk;
  logic        ok, mod_ok;
  logic [31:0] fr;

  assign job_stall = vld_r && out_stall;
  assign adv       = job_valid && !job_stall;

  always_comb begin
    logic c_ok, w_ok;
    logic [34:0] prod;
    c_ok = (job.chans == 16'd1) || (job.chans == 16'd2);
    w_ok = (job.bits == 16'd8) || (job.bits == 16'd16);
    blk  = {job.chans[1:0] == 2'd2 && job.bits[4], job.chans[1] ^ job.bits[4],
            job.chans[0] && !job.bits[4]};
    // Block size is 1, 2 or 4, so the remainder and quotient are masks and shifts.
    unique case (blk)
      3'd2:    begin mod_ok = !job.plen[0];         fr = {1'b0, job.plen[31:1]}; end
      3'd4:    begin mod_ok = job.plen[1:0] == 2'd0; fr = {2'b0, job.plen[31:2]}; end
      default: begin mod_ok = 1'b1;                 fr = job.plen; end
    endcase
    prod = {3'd0, job.rate} << (blk == 3'd4 ? 2 : (blk == 3'd2 ? 1 : 0));
    ok = 1'b0;
    if (job.hdr_err) st = ST_HEADER;
    else if (job.pre_status != ST_OK) st = job.pre_status;
    else if (job.fmt_code != 16'd1) st = ST_MISSING;
    else if (!c_ok || !w_ok || job.rate == '0 || job.align != {13'd0, blk} ||
             !mod_ok || prod != {3'd0, job.byte_rate}) st = ST_BAD_FORM;
    else begin
      st = ST_OK; ok = 1'b1;
    end
    if (!job.done) begin
      st = ST_OK; ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (!job_stall) vld_r <= job_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sv_r <= job.sample_valid; sb_r <= job.sample_byte; done_r <= job.done;
      st_r <= st;
      ch_r   <= ok ? job.chans[1:0] : 2'd0;
      rate_r <= ok ? job.rate : '0;
      bits_r <= ok ? job.bits[4:0] : 5'd0;
      blk_r  <= ok ? blk : 3'd0;
      plen_r <= ok ? fr : '0;
    end
  end

  logic [31:0] plen_keep_r;
  always_ff @(posedge clk) begin
    if (adv) plen_keep_r <= ok ? job.plen : '0;
  end

  assign out_valid           = vld_r;
  assign out_sample_valid    = sv_r;
  assign out_sample_byte     = sb_r;
  assign out_done_res        = done_r;
  assign out_status          = st_r;
  assign out_channel_count   = ch_r;
  assign out_sample_rate     = rate_r;
  assign out_bits_per_sample = bits_r;
  assign out_frame_count     = plen_r;
  assign out_frame_bytes     = blk_r;
  assign out_payload_length  = plen_keep_r;
endmodule

FILE: hdl/pcm_wave_chunk_parser.sv
// WAVE parser top level: front walk, two-word queue, back checker.
// Each accepted byte's result word is written into the queue, then into the back end's output
// registers, where an output stall holds it.
// Throughput: one byte per cycle while in_stall is low; each byte's walk update is a counter and compare.
// The queue lets the front keep accepting while a result waits at the output.
// Reset (rst_n low, synchronous) empties the queue and puts the walk at the file start.
// After a last byte the walk returns to the file start on its own.
module pcm_wave_chunk_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_sample_valid,
  output logic [7:0]  out_sample_byte,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic [1:0]  out_channel_count,
  output logic [31:0] out_sample_rate,
  output logic [4:0]  out_bits_per_sample,
  output logic [31:0] out_frame_count,
  output logic [2:0]  out_frame_bytes,
  output logic [31:0] out_payload_length
);
  import pwcp_pkg::*;

  logic q_wv, q_ws, q_rv, q_rs;
  job_t q_wj, q_rj;

  pwcp_front u_front (
    .clk, .rst_n, .in_valid, .in_data_byte, .in_last, .in_stall,
    .job_valid(q_wv), .job(q_wj), .job_stall(q_ws)
  );

  pwcp_queue u_queue (
    .clk, .rst_n, .wr_valid(q_wv), .wr_job(q_wj), .wr_stall(q_ws),
    .rd_valid(q_rv), .rd_job(q_rj), .rd_stall(q_rs)
  );

  pwcp_back u_back (
    .clk, .rst_n, .job_valid(q_rv), .job(q_rj), .job_stall(q_rs),
    .out_valid, .out_stall, .out_sample_valid, .out_sample_byte, .out_done_res,
    .out_status, .out_channel_count, .out_sample_rate, .out_bits_per_sample,
    .out_frame_count, .out_frame_bytes, .out_payload_length
  );
endmodule

FILE: hdl/pwcp_checker.sv
// Port-level assertions for the WAVE parser, bound to the top level.
module pwcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_sample_valid,
  input logic [7:0]  out_sample_byte,
  input logic        out_done_res,
  input logic [2:0]  out_status,
  input logic [1:0]  out_channel_count,
  input logic [2:0]  out_frame_bytes
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("stalled word changed");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_status == 3'd0 && out_channel_count == 2'd0)
    else $error("status outside last word");
  a_samp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sample_valid |-> out_sample_byte == 8'd0)
    else $error("sample byte without sample");
  a_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 3'd0 |-> out_frame_bytes == 3'd0)
    else $error("format shown with error");
endmodule

bind pcm_wave_chunk_parser pwcp_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_sample_valid, .out_sample_byte,
  .out_done_res, .out_status, .out_channel_count, .out_frame_bytes
);
